[sv/ops_pkg.sv]
// ----------------------------------------------------------------------------
// ops_pkg: shared types and constants of the cuff pressure sequencer
// beat payload structs, opcodes, register indexes and the mmHg conversion
// ----------------------------------------------------------------------------
package ops_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DUTY_W      = 10;
    localparam int MMHG_W      = 9;
    localparam int GAIN_W      = 15;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int CMP_W       = (SAMPLE_BITS > 10 ? SAMPLE_BITS : 10) + 1;

    // q16 gain and offset of the sensor transfer line
    localparam logic [GAIN_W-1:0] GAIN_Q16 = 15'd18088;
    localparam logic [20:0]       OFFS_Q16 = 21'd1545339;
    localparam logic [6:0]        ANALYSE_TICK_GATE = 7'd10;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SETPOINT = 2'd1,
        OP_PRESSURE = 2'd2,
        OP_TOGGLE   = 2'd3
    } t_opcode;

    localparam logic [2:0] REG_MAX_PRESSURE    = 3'd0;
    localparam logic [2:0] REG_MIN_PRESSURE    = 3'd1;
    localparam logic [2:0] REG_PULSE_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_VALVE_ON_TICKS  = 3'd3;
    localparam logic [2:0] REG_VALVE_PERIOD    = 3'd4;
    localparam logic [2:0] REG_SETTLE_TICKS    = 3'd5;
    localparam logic [2:0] REG_QUIET_LIMIT     = 3'd6;
    localparam logic [2:0] REG_WARMUP_SAMPLES  = 3'd7;

    typedef struct packed {
        t_opcode                opcode;
        logic [SAMPLE_BITS-1:0] sample_value;
    } t_in_beat;

    typedef struct packed {
        logic              valve_closed;
        logic [DUTY_W-1:0] pump_duty;
        logic [2:0]        phase;
        logic [MMHG_W-1:0] pressure_mmhg;
        logic [MMHG_W-1:0] systolic_mmhg;
        logic [MMHG_W-1:0] diastolic_mmhg;
    } t_out_beat;

    typedef struct packed {
        logic [9:0]  max_pressure;
        logic [9:0]  min_pressure;
        logic [9:0]  pulse_threshold;
        logic [6:0]  valve_on_ticks;
        logic [6:0]  valve_period;
        logic [7:0]  settle_ticks;
        logic [15:0] quiet_limit;
        logic [10:0] warmup_samples;
    } t_cfg;

    // floor(v*gain - offset) in q16, clamped at zero and at the field maximum
    function automatic logic [MMHG_W-1:0] to_mmhg(input logic [SAMPLE_BITS-1:0] v);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] diff;
        logic [PROD_W-1:0] whole;
        prod  = PROD_W'(v) * PROD_W'(GAIN_Q16);
        diff  = prod - PROD_W'(OFFS_Q16);
        whole = diff >> 16;
        if (prod <= PROD_W'(OFFS_Q16)) begin
            return '0;
        end else if (whole > PROD_W'({MMHG_W{1'b1}})) begin
            return {MMHG_W{1'b1}};
        end else begin
            return whole[MMHG_W-1:0];
        end
    endfunction

endpackage

[sv/oscillometric_pressure_sequencer_top.sv]
// ----------------------------------------------------------------------------
// oscillometric_pressure_sequencer_top: cuff measurement phase sequencer
// path: a command beat is held in the input register, its result beat in the result register
// throughput: one beat per cycle while the status channel does not stall, set by the single-pass state update
// reset: synchronous active-low, state cleared, registers to defaults
// ----------------------------------------------------------------------------
module oscillometric_pressure_sequencer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ops_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ops_pkg::t_out_beat o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INFLATE = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_DEFLATE = 3'd3,
        PH_RELEASE = 3'd4,
        PH_HOLD    = 3'd5
    } t_phase;

    localparam int SB = ops_pkg::SAMPLE_BITS;
    localparam int CW = ops_pkg::CMP_W;

    ops_pkg::t_cfg      r_cfg;
    logic               r_in_valid;
    ops_pkg::t_in_beat  r_in_data;
    logic               r_out_valid;
    ops_pkg::t_out_beat r_out_data;

    t_phase             r_phase,   n_phase;
    logic               r_valve,   n_valve;
    logic [ops_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [6:0]         r_tick,    n_tick;
    logic [8:0]         r_settle,  n_settle;
    logic [8:0]         r_hold,    n_hold;
    logic [SB-1:0]      r_min,     n_min;
    logic [10:0]        r_defl,    n_defl;
    logic [15:0]        r_quiet,   n_quiet;
    logic [SB-1:0]      r_sys,     n_sys;
    logic [SB-1:0]      r_dia,     n_dia;
    logic [SB-1:0]      r_last,    n_last;

    logic               out_free;
    logic               proc;
    logic               cfg_wr;
    logic [SB-1:0]      s;
    ops_pkg::t_out_beat n_out;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign s           = r_in_data.sample_value;

    always_comb begin
        unique case (paddr[4:2])
            ops_pkg::REG_MAX_PRESSURE:    prdata = 32'(r_cfg.max_pressure);
            ops_pkg::REG_MIN_PRESSURE:    prdata = 32'(r_cfg.min_pressure);
            ops_pkg::REG_PULSE_THRESHOLD: prdata = 32'(r_cfg.pulse_threshold);
            ops_pkg::REG_VALVE_ON_TICKS:  prdata = 32'(r_cfg.valve_on_ticks);
            ops_pkg::REG_VALVE_PERIOD:    prdata = 32'(r_cfg.valve_period);
            ops_pkg::REG_SETTLE_TICKS:    prdata = 32'(r_cfg.settle_ticks);
            ops_pkg::REG_QUIET_LIMIT:     prdata = 32'(r_cfg.quiet_limit);
            ops_pkg::REG_WARMUP_SAMPLES:  prdata = 32'(r_cfg.warmup_samples);
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_valve  = r_valve;
        n_duty   = r_duty;
        n_tick   = r_tick;
        n_settle = r_settle;
        n_hold   = r_hold;
        n_min    = r_min;
        n_defl   = r_defl;
        n_quiet  = r_quiet;
        n_sys    = r_sys;
        n_dia    = r_dia;
        n_last   = r_last;
        unique case (r_in_data.opcode)
            ops_pkg::OP_TICK: begin
                if (r_phase == PH_DEFLATE) begin
                    n_tick = (r_tick == '1) ? r_tick : r_tick + 7'd1;
                    if (n_tick < r_cfg.valve_on_ticks) begin
                        n_valve = 1'b1;
                    end else begin
                        n_valve = 1'b0;
                        if (n_tick >= r_cfg.valve_period) begin
                            n_tick = '0;
                        end
                    end
                end else if (r_phase == PH_RELEASE || r_phase == PH_IDLE) begin
                    n_valve = 1'b1;
                end else begin
                    n_valve = 1'b0;
                end
            end
            ops_pkg::OP_SETPOINT: begin
                if (r_phase == PH_INFLATE) begin
                    n_duty = ops_pkg::DUTY_W'(s);
                end
            end
            ops_pkg::OP_PRESSURE: begin
                n_last = s;
                unique case (r_phase)
                    PH_IDLE: begin
                        n_duty = '0;
                    end
                    PH_INFLATE: begin
                        if (CW'(s) >= CW'(r_cfg.max_pressure)) begin
                            n_duty   = '0;
                            n_phase  = PH_SETTLE;
                            n_settle = '0;
                        end
                    end
                    PH_SETTLE: begin
                        n_settle = (r_settle == '1) ? r_settle : r_settle + 9'd1;
                        if (n_settle > 9'(r_cfg.settle_ticks)) begin
                            n_phase = PH_DEFLATE;
                            n_min   = '0;
                            n_defl  = '0;
                            n_quiet = '0;
                        end
                    end
                    PH_DEFLATE: begin
                        if (CW'(s) < CW'(r_cfg.min_pressure)) begin
                            n_phase = PH_RELEASE;
                        end else begin
                            if (r_tick > ops_pkg::ANALYSE_TICK_GATE) begin
                                n_defl = (r_defl == '1) ? r_defl : r_defl + 11'd1;
                                // zero minimum means no sample seen yet
                                if (r_min == '0 || s <= r_min) begin
                                    n_min = s;
                                end
                                if (n_defl > r_cfg.warmup_samples && !r_valve) begin
                                    if (CW'(s) > CW'(n_min) + CW'(r_cfg.pulse_threshold))
                                    begin
                                        if (r_sys == '0) begin
                                            n_sys = s;
                                        end
                                        n_dia   = s;
                                        n_quiet = '0;
                                    end else if (r_sys != '0) begin
                                        n_quiet = (r_quiet == '1) ? r_quiet
                                                                  : r_quiet + 16'd1;
                                    end
                                end
                            end
                            if (n_sys != '0 && n_quiet >= r_cfg.quiet_limit) begin
                                n_phase = PH_RELEASE;
                            end
                        end
                    end
                    PH_RELEASE: begin
                        if (CW'(s) < CW'(r_cfg.min_pressure)) begin
                            n_phase = PH_HOLD;
                            n_hold  = '0;
                        end
                    end
                    PH_HOLD: begin
                        n_hold = (r_hold == '1) ? r_hold : r_hold + 9'd1;
                        if (n_hold > 9'(r_cfg.settle_ticks)) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            ops_pkg::OP_TOGGLE: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_INFLATE;
                    n_sys   = '0;
                    n_dia   = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        n_out.valve_closed   = n_valve;
        n_out.pump_duty      = n_duty;
        n_out.phase          = 3'(n_phase);
        n_out.pressure_mmhg  = ops_pkg::to_mmhg(n_last);
        n_out.systolic_mmhg  = ops_pkg::to_mmhg(n_sys);
        n_out.diastolic_mmhg = ops_pkg::to_mmhg(n_dia);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_pressure    <= 10'd800;
            r_cfg.min_pressure    <= 10'd140;
            r_cfg.pulse_threshold <= 10'd10;
            r_cfg.valve_on_ticks  <= 7'd3;
            r_cfg.valve_period    <= 7'd80;
            r_cfg.settle_ticks    <= 8'd66;
            r_cfg.quiet_limit     <= 16'd133;
            r_cfg.warmup_samples  <= 11'd200;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                ops_pkg::REG_MAX_PRESSURE:    r_cfg.max_pressure    <= pwdata[9:0];
                ops_pkg::REG_MIN_PRESSURE:    r_cfg.min_pressure    <= pwdata[9:0];
                ops_pkg::REG_PULSE_THRESHOLD: r_cfg.pulse_threshold <= pwdata[9:0];
                ops_pkg::REG_VALVE_ON_TICKS:  r_cfg.valve_on_ticks  <= pwdata[6:0];
                ops_pkg::REG_VALVE_PERIOD:    r_cfg.valve_period    <= pwdata[6:0];
                ops_pkg::REG_SETTLE_TICKS:    r_cfg.settle_ticks    <= pwdata[7:0];
                ops_pkg::REG_QUIET_LIMIT:     r_cfg.quiet_limit     <= pwdata[15:0];
                ops_pkg::REG_WARMUP_SAMPLES:  r_cfg.warmup_samples  <= pwdata[10:0];
                default:                      r_cfg.max_pressure    <= r_cfg.max_pressure;
            endcase
        end
    end

    // input register and result register, each holds while the next side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (proc) begin
            r_out_data <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_valve  <= 1'b0;
            r_duty   <= '0;
            r_tick   <= '0;
            r_settle <= '0;
            r_hold   <= '0;
            r_min    <= '0;
            r_defl   <= '0;
            r_quiet  <= '0;
            r_sys    <= '0;
            r_dia    <= '0;
            r_last   <= '0;
        end else if (proc) begin
            r_phase  <= n_phase;
            r_valve  <= n_valve;
            r_duty   <= n_duty;
            r_tick   <= n_tick;
            r_settle <= n_settle;
            r_hold   <= n_hold;
            r_min    <= n_min;
            r_defl   <= n_defl;
            r_quiet  <= n_quiet;
            r_sys    <= n_sys;
            r_dia    <= n_dia;
            r_last   <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed beat did not reach the result register");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_dia_follows_sys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sys == '0) |-> (r_dia == '0))
        else $error("diastolic captured without systolic");
`endif

endmodule

[tb/cuff_sequence_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cuff_sequence_checker: status predictor and scoreboard for the sequencer
// watches the command and status channels and the register port, steps its
// own copy of the phase machine per command beat and compares status beats
// ----------------------------------------------------------------------------
module cuff_sequence_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  ops_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ops_pkg::t_out_beat i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_compared,
    output logic [7:0]         o_phases_seen,
    output logic               o_model_idle
);
    import ops_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INFLATE = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_DEFLATE = 3'd3,
        PH_RELEASE = 3'd4,
        PH_HOLD    = 3'd5
    } t_phase;

    localparam t_cfg CFG_RESET = '{
        max_pressure: 10'd800, min_pressure: 10'd140, pulse_threshold: 10'd10,
        valve_on_ticks: 7'd3, valve_period: 7'd80, settle_ticks: 8'd66,
        quiet_limit: 16'd133, warmup_samples: 11'd200
    };

    t_cfg        cfg;
    t_phase      ph;
    logic        valve;
    logic [9:0]  duty;
    logic [6:0]  ticks;
    logic [8:0]  settle_cnt;
    logic [8:0]  hold_cnt;
    logic [9:0]  run_min;
    logic [10:0] dfl_cnt;
    logic [15:0] quiet_cnt;
    logic [9:0]  sys_raw;
    logic [9:0]  dia_raw;
    logic [9:0]  last_p;

    t_out_beat status_due_q[$];
    t_out_beat want;
    int        mismatches;
    int        compared;
    logic [7:0] phases_seen;

    function automatic logic [8:0] mmhg_of(input logic [9:0] raw);
        logic [63:0] prod;
        logic [63:0] whole;
        prod = 64'(raw) * 64'(GAIN_Q16);
        if (prod <= 64'(OFFS_Q16)) begin
            return '0;
        end
        whole = (prod - 64'(OFFS_Q16)) >> 16;
        return (whole > 64'd511) ? 9'd511 : whole[8:0];
    endfunction

    function automatic void clear_machine();
        ph         = PH_IDLE;
        valve      = 1'b0;
        duty       = '0;
        ticks      = '0;
        settle_cnt = '0;
        hold_cnt   = '0;
        run_min    = '0;
        dfl_cnt    = '0;
        quiet_cnt  = '0;
        sys_raw    = '0;
        dia_raw    = '0;
        last_p     = '0;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_MAX_PRESSURE:    cfg.max_pressure    = val[9:0];
            REG_MIN_PRESSURE:    cfg.min_pressure    = val[9:0];
            REG_PULSE_THRESHOLD: cfg.pulse_threshold = val[9:0];
            REG_VALVE_ON_TICKS:  cfg.valve_on_ticks  = val[6:0];
            REG_VALVE_PERIOD:    cfg.valve_period    = val[6:0];
            REG_SETTLE_TICKS:    cfg.settle_ticks    = val[7:0];
            REG_QUIET_LIMIT:     cfg.quiet_limit     = val[15:0];
            REG_WARMUP_SAMPLES:  cfg.warmup_samples  = val[10:0];
            default: ;
        endcase
    endfunction

    function automatic void valve_tick();
        if (ph == PH_DEFLATE) begin
            if (ticks != 7'd127) ticks = ticks + 7'd1;
            if (ticks < cfg.valve_on_ticks) begin
                valve = 1'b1;
            end else begin
                valve = 1'b0;
                if (ticks >= cfg.valve_period) ticks = '0;
            end
        end else begin
            valve = (ph == PH_RELEASE || ph == PH_IDLE);
        end
    endfunction

    function automatic void deflate_sample(input logic [9:0] p);
        if (p < cfg.min_pressure) begin
            ph = PH_RELEASE;
            return;
        end
        if (ticks > ANALYSE_TICK_GATE) begin
            if (dfl_cnt != 11'd2047) dfl_cnt = dfl_cnt + 11'd1;
            if (run_min == '0 || p <= run_min) run_min = p;
            if (dfl_cnt > cfg.warmup_samples && !valve) begin
                // pulse when the sample clears the running floor by the threshold
                if (11'(p) > 11'(run_min) + 11'(cfg.pulse_threshold)) begin
                    if (sys_raw == '0) sys_raw = p;
                    dia_raw   = p;
                    quiet_cnt = '0;
                end else if (sys_raw != '0) begin
                    if (quiet_cnt != 16'hFFFF) quiet_cnt = quiet_cnt + 16'd1;
                end
            end
        end
        if (sys_raw != '0 && quiet_cnt >= cfg.quiet_limit) ph = PH_RELEASE;
    endfunction

    function automatic void pressure_sample(input logic [9:0] p);
        last_p = p;
        case (ph)
            PH_IDLE: duty = '0;
            PH_INFLATE: begin
                if (p >= cfg.max_pressure) begin
                    duty       = '0;
                    ph         = PH_SETTLE;
                    settle_cnt = '0;
                end
            end
            PH_SETTLE: begin
                if (settle_cnt != 9'd511) settle_cnt = settle_cnt + 9'd1;
                if (settle_cnt > cfg.settle_ticks) begin
                    ph        = PH_DEFLATE;
                    run_min   = '0;
                    dfl_cnt   = '0;
                    quiet_cnt = '0;
                end
            end
            PH_DEFLATE: deflate_sample(p);
            PH_RELEASE: begin
                if (p < cfg.min_pressure) begin
                    ph       = PH_HOLD;
                    hold_cnt = '0;
                end
            end
            default: begin
                if (hold_cnt != 9'd511) hold_cnt = hold_cnt + 9'd1;
                if (hold_cnt > cfg.settle_ticks) ph = PH_IDLE;
            end
        endcase
    endfunction

    // advance the phase machine by one command beat, return the status it shows
    function automatic t_out_beat step_sequencer(input t_in_beat cmd);
        t_out_beat st;
        case (cmd.opcode)
            OP_TICK:     valve_tick();
            OP_SETPOINT: if (ph == PH_INFLATE) duty = cmd.sample_value;
            OP_PRESSURE: pressure_sample(cmd.sample_value);
            default: begin
                if (ph == PH_IDLE) begin
                    ph      = PH_INFLATE;
                    sys_raw = '0;
                    dia_raw = '0;
                end else begin
                    ph = PH_IDLE;
                end
            end
        endcase
        st.valve_closed   = valve;
        st.pump_duty      = duty;
        st.phase          = ph;
        st.pressure_mmhg  = mmhg_of(last_p);
        st.systolic_mmhg  = mmhg_of(sys_raw);
        st.diastolic_mmhg = mmhg_of(dia_raw);
        return st;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = CFG_RESET;
            clear_machine();
            status_due_q.delete();
            mismatches  = 0;
            compared    = 0;
            phases_seen = 8'h01;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                store_reg(i_paddr[4:2], i_pwdata);
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_due_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: status beat with nothing pending: %p", $realtime,
                                 i_out_data);
                    end
                    mismatches++;
                end else begin
                    want = status_due_q.pop_front();
                    compared++;
                    if (i_out_data.valve_closed   !== want.valve_closed   ||
                        i_out_data.pump_duty      !== want.pump_duty      ||
                        i_out_data.phase          !== want.phase          ||
                        i_out_data.pressure_mmhg  !== want.pressure_mmhg  ||
                        i_out_data.systolic_mmhg  !== want.systolic_mmhg  ||
                        i_out_data.diastolic_mmhg !== want.diastolic_mmhg) begin
                        if (mismatches < 10) begin
                            $display("%0t: status #%0d valve/duty/phase/p/sys/dia",
                                     $realtime, compared);
                            $display("    want %0d %0d %0d %0d %0d %0d",
                                     want.valve_closed, want.pump_duty, want.phase,
                                     want.pressure_mmhg, want.systolic_mmhg,
                                     want.diastolic_mmhg);
                            $display("    got  %0d %0d %0d %0d %0d %0d",
                                     i_out_data.valve_closed, i_out_data.pump_duty,
                                     i_out_data.phase, i_out_data.pressure_mmhg,
                                     i_out_data.systolic_mmhg, i_out_data.diastolic_mmhg);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_due_q.push_back(step_sequencer(i_in_data));
                phases_seen[ph] = 1'b1;
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= status_due_q.size();
        o_compared    <= compared;
        o_phases_seen <= phases_seen;
        o_model_idle  <= (ph == PH_IDLE);
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the oscillometric pressure sequencer
// directed beats under reset defaults, then measurement sessions with random
// content under several register settings; random command gaps and status stalls
// but for a calm last stretch, status beats checked by the checker module
// ----------------------------------------------------------------------------
module tb_top;
    import ops_pkg::*;

    localparam t_cfg CFG_RESET = '{
        max_pressure: 10'd800, min_pressure: 10'd140, pulse_threshold: 10'd10,
        valve_on_ticks: 7'd3, valve_period: 7'd80, settle_ticks: 8'd66,
        quiet_limit: 16'd133, warmup_samples: 11'd200
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_beat    in_beat = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          compared;
    logic [7:0]  phases_seen;
    logic        model_idle;

    t_cfg        cur;
    bit          calm = 1'b0;
    int          beats_sent = 0;
    int          settings_used = 0;
    int          stall_left = 0;

    oscillometric_pressure_sequencer_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cuff_sequence_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_phases_seen(phases_seen),
        .o_model_idle (model_idle)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d status beats outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // status channel back-pressure in random bursts
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left == 0) begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(0, 14);
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    task automatic send_beat(input t_opcode op, input int v);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{opcode: op, sample_value: v[SAMPLE_BITS-1:0]};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // hold off until every status beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic program_regs(input t_cfg c);
        drain();
        write_reg(REG_MAX_PRESSURE, 32'(c.max_pressure));
        write_reg(REG_MIN_PRESSURE, 32'(c.min_pressure));
        write_reg(REG_PULSE_THRESHOLD, 32'(c.pulse_threshold));
        write_reg(REG_VALVE_ON_TICKS, 32'(c.valve_on_ticks));
        write_reg(REG_VALVE_PERIOD, 32'(c.valve_period));
        write_reg(REG_SETTLE_TICKS, 32'(c.settle_ticks));
        write_reg(REG_QUIET_LIMIT, 32'(c.quiet_limit));
        write_reg(REG_WARMUP_SAMPLES, 32'(c.warmup_samples));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur = c;
        settings_used++;
    endtask

    // short settle, short warmup and a fast valve so sessions reach detection
    function automatic t_cfg quick_cfg();
        t_cfg c;
        c.max_pressure    = 10'($urandom_range(300, 900));
        c.min_pressure    = 10'($urandom_range(40, 250));
        c.pulse_threshold = 10'($urandom_range(5, 60));
        c.valve_on_ticks  = 7'($urandom_range(1, 6));
        c.valve_period    = 7'($urandom_range(14, 40));
        c.settle_ticks    = 8'($urandom_range(1, 8));
        c.quiet_limit     = 16'($urandom_range(2, 15));
        c.warmup_samples  = 11'($urandom_range(0, 12));
        return c;
    endfunction

    // one measurement: start, inflate, settle, deflate with pulses, release, hold
    task automatic run_session(input int defl_len);
        int n;
        int got;
        int base;
        int v;
        int r;
        int lo;
        drain();
        if (!model_idle) send_beat(OP_TOGGLE, $urandom);
        send_beat(OP_TOGGLE, $urandom);
        n = $urandom_range(1, 6);
        repeat (n) begin
            if (cur.max_pressure == 0 || $urandom_range(0, 1) == 0) begin
                send_beat(OP_SETPOINT, $urandom);
            end else begin
                send_beat(OP_PRESSURE, $urandom_range(0, int'(cur.max_pressure) - 1));
            end
        end
        send_beat(OP_PRESSURE, $urandom_range(int'(cur.max_pressure), 1023));
        n = (cur.settle_ticks <= 80) ? int'(cur.settle_ticks) + 1 : 40;
        got = 0;
        while (got < n) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(OP_TICK, $urandom);
            end else begin
                send_beat(OP_PRESSURE, $urandom);
                got++;
            end
        end
        lo   = int'(cur.min_pressure);
        base = $urandom_range(lo, 1023);
        repeat (defl_len) begin
            r = $urandom_range(0, 19);
            if (r < 9) begin
                send_beat(OP_TICK, $urandom);
            end else if (r < 18) begin
                if ($urandom_range(0, 2) == 0) begin
                    v = base + int'(cur.pulse_threshold) + $urandom_range(1, 40);
                end else begin
                    v = base - $urandom_range(0, 3);
                end
                if (v > 1023) v = 1023;
                if (v < lo) v = lo;
                send_beat(OP_PRESSURE, v);
                base = base - $urandom_range(0, 2);
                if (base < lo) base = lo;
            end else if (r == 18) begin
                send_beat(OP_SETPOINT, $urandom);
            end else begin
                send_beat(OP_PRESSURE, $urandom);
            end
        end
        repeat (2) begin
            send_beat(OP_PRESSURE, (lo == 0) ? 0 : $urandom_range(0, lo - 1));
        end
        n = (cur.settle_ticks <= 80) ? int'(cur.settle_ticks) + 1 : 20;
        repeat (n) send_beat(OP_PRESSURE, $urandom);
        if ($urandom_range(0, 3) == 0) send_beat(OP_TOGGLE, $urandom);
    endtask

    initial begin
        t_cfg c;
        cur = CFG_RESET;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: every opcode in idle and inflate; setpoint, tick and toggle in settle
        send_beat(OP_TICK, 0);
        send_beat(OP_SETPOINT, 1023);
        send_beat(OP_PRESSURE, 0);
        send_beat(OP_PRESSURE, 1023);
        send_beat(OP_TOGGLE, 0);
        send_beat(OP_SETPOINT, 1023);
        send_beat(OP_SETPOINT, 0);
        send_beat(OP_TICK, 0);
        send_beat(OP_PRESSURE, 799);
        send_beat(OP_SETPOINT, 341);
        send_beat(OP_PRESSURE, 800);
        send_beat(OP_SETPOINT, 682);
        send_beat(OP_TICK, 1023);
        send_beat(OP_TOGGLE, 1023);
        send_beat(OP_TOGGLE, 0);
        send_beat(OP_SETPOINT, 1023);
        // stop keeps the duty until a pressure beat in idle
        send_beat(OP_TOGGLE, 0);
        send_beat(OP_SETPOINT, 5);
        send_beat(OP_PRESSURE, 512);
        send_beat(OP_TOGGLE, 0);
        send_beat(OP_PRESSURE, 1023);
        send_beat(OP_PRESSURE, 0);
        send_beat(OP_TOGGLE, 0);

        program_regs(quick_cfg());
        repeat (3) run_session(30);

        // low extremes
        program_regs('{max_pressure: 10'd0, min_pressure: 10'd0, pulse_threshold: 10'd0,
                       valve_on_ticks: 7'd0, valve_period: 7'd1, settle_ticks: 8'd0,
                       quiet_limit: 16'd0, warmup_samples: 11'd0});
        run_session(15);

        // zero valve period wraps on every open tick
        c = quick_cfg();
        c.valve_period   = 7'd0;
        c.valve_on_ticks = 7'($urandom_range(0, 127));
        program_regs(c);
        repeat (2) run_session(30);

        // high extremes
        program_regs('{max_pressure: 10'd1023, min_pressure: 10'd1023,
                       pulse_threshold: 10'd1023, valve_on_ticks: 7'd127,
                       valve_period: 7'd127, settle_ticks: 8'd255,
                       quiet_limit: 16'hFFFF, warmup_samples: 11'd2047});
        run_session(30);

        // last stretch runs with neither gaps nor stalls
        program_regs(quick_cfg());
        calm = 1'b1;
        repeat (3) run_session(30);

        drain();
        repeat (10) @(posedge clk);
        $display("%0d command beats under %0d register settings, %0d status beats compared",
                 beats_sent, settings_used, compared);
        $display("phases reached (bit per phase, idle lowest): %b", phases_seen[5:0]);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
